[rtl/pogb_pkg.sv]
// Package for the point occupancy grid binner.
// Grid geometry, register map, op and sector codes, and the cell coordinate function.
// No dependencies.
package pogb_pkg;

    localparam int GRID_SIDE  = 160;
    localparam int CELL_COUNT = GRID_SIDE * GRID_SIDE;
    localparam int ADDR_W     = $clog2(CELL_COUNT);
    localparam int GC_W       = $clog2(GRID_SIDE);

    localparam int CELL_W     = 7;
    localparam int IDX_W      = 15;
    localparam int CNT_W      = 16;
    localparam int COORD_W    = 16;
    localparam int CFG_W      = 15;
    localparam int CFG_IDX_W  = 3;

    localparam logic [CELL_W-1:0] CELL_MAX = 7'd100;
    localparam logic [CNT_W-1:0]  CNT_MAX  = 16'hFFFF;

    // register map
    localparam logic [CFG_IDX_W-1:0] CFG_GRID_HALF_RANGE = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_CELL_SHIFT      = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_HIT_INCREMENT   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_HALF_LENGTH     = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_HALF_WIDTH      = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_SECTOR_EDGE     = 3'd5;

    localparam logic [14:0] RST_GRID_HALF_RANGE = 15'd10240;
    localparam logic [3:0]  RST_CELL_SHIFT      = 4'd7;
    localparam logic [6:0]  RST_HIT_INCREMENT   = 7'd10;
    localparam logic [14:0] RST_HALF_LENGTH     = 15'd384;
    localparam logic [14:0] RST_HALF_WIDTH      = 15'd256;
    localparam logic [14:0] RST_SECTOR_EDGE     = 15'd512;

    typedef enum logic [1:0] {
        OP_POINT = 2'd0,
        OP_READ  = 2'd1,
        OP_FRAME = 2'd2
    } t_op;

    typedef enum logic [2:0] {
        SEC_NONE  = 3'd0,
        SEC_FRONT = 3'd1,
        SEC_BACK  = 3'd2,
        SEC_LEFT  = 3'd3,
        SEC_RIGHT = 3'd4
    } t_sector;

    typedef enum logic [1:0] {
        S_CLEAR,
        S_IDLE,
        S_ADDR,
        S_UPD
    } t_state;

    typedef struct packed {
        logic load;    // capture request, compute coordinates
        logic rd;      // form address, read cell
        logic commit;  // write back, load result register
        logic clr_wr;  // clearing sweep write
    } t_dp_cmd;

    typedef struct packed {
        logic is_frame;
        logic clr_last;
    } t_dp_status;

    // offset from grid corner, rounded shift, clamped to the last cell
    function automatic logic [GC_W-1:0] grid_coord(
        input logic [COORD_W-1:0] c,
        input logic [14:0]        r,
        input logic [3:0]         sh
    );
        logic [17:0] off;
        logic [17:0] g;
        off = {{2{c[COORD_W-1]}}, c} + {3'b000, r} + ((18'd1 << sh) >> 1);
        g   = off >> sh;
        grid_coord = (g > 18'(GRID_SIDE - 1)) ? GC_W'(GRID_SIDE - 1) : GC_W'(g);
    endfunction

endpackage

[rtl/pogb_ram.sv]
// Generic simple dual-port RAM, one write and one registered read port.
// No dependencies.
module pogb_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

[rtl/pogb_ctrl.sv]
// Controller for the point occupancy grid binner: sequencer and result valid.
// Depends on pogb_pkg.
module pogb_ctrl (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    output logic                  o_in_stall,
    output logic                  o_out_valid,
    input  logic                  i_out_stall,
    input  pogb_pkg::t_dp_status  i_status,
    output pogb_pkg::t_dp_cmd     o_cmd
);

    pogb_pkg::t_state r_state;
    pogb_pkg::t_state n_state;
    logic             r_out_valid;
    logic             n_out_valid;
    logic             out_free;

    assign out_free = !r_out_valid || !i_out_stall;

    always_comb begin
        n_state = r_state;
        case (r_state)
            pogb_pkg::S_CLEAR: begin
                if (i_status.clr_last) begin
                    n_state = pogb_pkg::S_IDLE;
                end
            end
            pogb_pkg::S_IDLE: begin
                if (i_in_valid) begin
                    n_state = pogb_pkg::S_ADDR;
                end
            end
            pogb_pkg::S_ADDR: begin
                n_state = pogb_pkg::S_UPD;
            end
            pogb_pkg::S_UPD: begin
                if (out_free) begin
                    n_state = i_status.is_frame ? pogb_pkg::S_CLEAR : pogb_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = pogb_pkg::S_CLEAR;
            end
        endcase
    end

    always_comb begin
        o_cmd      = '0;
        o_in_stall = 1'b1;
        case (r_state)
            pogb_pkg::S_CLEAR: begin
                o_cmd.clr_wr = 1'b1;
            end
            pogb_pkg::S_IDLE: begin
                o_in_stall = 1'b0;
                o_cmd.load = i_in_valid;
            end
            pogb_pkg::S_ADDR: begin
                o_cmd.rd = 1'b1;
            end
            pogb_pkg::S_UPD: begin
                o_cmd.commit = out_free;
            end
            default: begin
                o_cmd = '0;
            end
        endcase
    end

    always_comb begin
        if (o_cmd.commit) begin
            n_out_valid = 1'b1;
        end else if (!i_out_stall) begin
            n_out_valid = 1'b0;
        end else begin
            n_out_valid = r_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= pogb_pkg::S_CLEAR;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_out_valid = r_out_valid;

`ifndef SYNTHESIS
    a_commit_into_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.commit |-> !(r_out_valid && i_out_stall))
        else $error("result loaded over a held result");

    a_commit_shows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.commit |=> o_out_valid)
        else $error("committed result not presented");

    a_item_sequence: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall) |=> r_state == pogb_pkg::S_ADDR ##1
            r_state == pogb_pkg::S_UPD)
        else $error("accepted request did not walk address and update steps");

    a_clear_ends: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == pogb_pkg::S_CLEAR && i_status.clr_last) |=> r_state == pogb_pkg::S_IDLE)
        else $error("clearing sweep did not end at last cell");
`endif

endmodule

[rtl/pogb_dp.sv]
// Datapath for the point occupancy grid binner: config registers, cell math,
// sector counters, cell RAM and result register. Depends on pogb_pkg, pogb_ram.
module pogb_dp (
    input  logic                                    i_clk,
    input  logic                                    i_rst_n,
    input  pogb_pkg::t_dp_cmd                       i_cmd,
    output pogb_pkg::t_dp_status                    o_status,
    input  logic                                    i_cfg_we,
    input  logic [pogb_pkg::CFG_IDX_W-1:0]          i_cfg_idx,
    input  logic [pogb_pkg::CFG_W-1:0]              i_cfg_wdata,
    input  logic [1:0]                              i_op,
    input  logic signed [pogb_pkg::COORD_W-1:0]     i_point_x,
    input  logic signed [pogb_pkg::COORD_W-1:0]     i_point_y,
    input  logic [pogb_pkg::IDX_W-1:0]              i_read_index,
    output logic                                    o_in_range,
    output logic [pogb_pkg::IDX_W-1:0]              o_cell_index,
    output logic [pogb_pkg::CELL_W-1:0]             o_cell_value,
    output logic [2:0]                              o_sector,
    output logic signed [pogb_pkg::COORD_W-1:0]     o_out_x,
    output logic signed [pogb_pkg::COORD_W-1:0]     o_out_y,
    output logic [pogb_pkg::CNT_W-1:0]              o_slot,
    output logic [pogb_pkg::CNT_W-1:0]              o_front_count,
    output logic [pogb_pkg::CNT_W-1:0]              o_back_count,
    output logic [pogb_pkg::CNT_W-1:0]              o_left_count,
    output logic [pogb_pkg::CNT_W-1:0]              o_right_count
);

    // configuration
    logic [14:0] r_half_range;
    logic [3:0]  r_cell_shift;
    logic [6:0]  r_hit_inc;
    logic [14:0] r_half_length;
    logic [14:0] r_half_width;
    logic [14:0] r_sector_edge;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_half_range  <= pogb_pkg::RST_GRID_HALF_RANGE;
            r_cell_shift  <= pogb_pkg::RST_CELL_SHIFT;
            r_hit_inc     <= pogb_pkg::RST_HIT_INCREMENT;
            r_half_length <= pogb_pkg::RST_HALF_LENGTH;
            r_half_width  <= pogb_pkg::RST_HALF_WIDTH;
            r_sector_edge <= pogb_pkg::RST_SECTOR_EDGE;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                pogb_pkg::CFG_GRID_HALF_RANGE: r_half_range  <= i_cfg_wdata;
                pogb_pkg::CFG_CELL_SHIFT:      r_cell_shift  <= i_cfg_wdata[3:0];
                pogb_pkg::CFG_HIT_INCREMENT:   r_hit_inc     <= i_cfg_wdata[6:0];
                pogb_pkg::CFG_HALF_LENGTH:     r_half_length <= i_cfg_wdata;
                pogb_pkg::CFG_HALF_WIDTH:      r_half_width  <= i_cfg_wdata;
                pogb_pkg::CFG_SECTOR_EDGE:     r_sector_edge <= i_cfg_wdata;
                default: ;
            endcase
        end
    end

    // request capture: range test, sector class and grid coordinates from the ports
    logic signed [16:0] xs, ys, ax, ay, rng, hl, hw, edg, edg_n;
    logic               in_rng, gate;
    pogb_pkg::t_sector  sec_c;

    always_comb begin
        xs    = {i_point_x[15], i_point_x};
        ys    = {i_point_y[15], i_point_y};
        ax    = i_point_x[15] ? -xs : xs;
        ay    = i_point_y[15] ? -ys : ys;
        rng   = signed'({2'b00, r_half_range});
        hl    = signed'({2'b00, r_half_length});
        hw    = signed'({2'b00, r_half_width});
        edg   = signed'({2'b00, r_sector_edge});
        edg_n = -edg;
        in_rng = (ax <= rng) && (ay <= rng);
        gate   = (ax >= hl) && (ay >= hw);
        sec_c  = pogb_pkg::SEC_NONE;
        if (gate) begin
            if (xs >= edg && ay <= edg) begin
                sec_c = pogb_pkg::SEC_FRONT;
            end else if (xs <= edg_n && ay <= edg) begin
                sec_c = pogb_pkg::SEC_BACK;
            end else if (ys >= edg) begin
                sec_c = pogb_pkg::SEC_LEFT;
            end else if (ys <= edg_n) begin
                sec_c = pogb_pkg::SEC_RIGHT;
            end
        end
    end

    pogb_pkg::t_op                       r_op;
    logic [1:0]                          r_op_raw;
    logic signed [pogb_pkg::COORD_W-1:0] r_x, r_y;
    logic [pogb_pkg::IDX_W-1:0]          r_rd_idx;
    logic                                r_in_range, r_read_ok;
    pogb_pkg::t_sector                   r_sec;
    logic [pogb_pkg::GC_W-1:0]           r_gx, r_gy;
    logic [pogb_pkg::ADDR_W-1:0]         r_addr;

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_op_raw   <= i_op;
            r_x        <= i_point_x;
            r_y        <= i_point_y;
            r_rd_idx   <= i_read_index;
            r_in_range <= in_rng;
            r_read_ok  <= 32'(i_read_index) < 32'(pogb_pkg::CELL_COUNT);
            r_sec      <= sec_c;
            r_gx       <= pogb_pkg::grid_coord(i_point_x, r_half_range, r_cell_shift);
            r_gy       <= pogb_pkg::grid_coord(i_point_y, r_half_range, r_cell_shift);
        end
    end

    assign r_op = pogb_pkg::t_op'(r_op_raw);

    // cell address and RAM read
    logic [pogb_pkg::ADDR_W-1:0] addr_c;
    logic                        re;

    always_comb begin
        if (r_op == pogb_pkg::OP_READ) begin
            addr_c = pogb_pkg::ADDR_W'(r_rd_idx);
            re     = i_cmd.rd && r_read_ok;
        end else begin
            addr_c = pogb_pkg::ADDR_W'(r_gy) * pogb_pkg::ADDR_W'(pogb_pkg::GRID_SIDE)
                   + pogb_pkg::ADDR_W'(r_gx);
            re     = i_cmd.rd && r_in_range && (r_op == pogb_pkg::OP_POINT);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.rd) begin
            r_addr <= addr_c;
        end
    end

    // clearing sweep pointer
    logic [pogb_pkg::ADDR_W-1:0] r_clr_ptr;
    logic                        clr_last;

    assign clr_last = (r_clr_ptr == pogb_pkg::ADDR_W'(pogb_pkg::CELL_COUNT - 1));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_ptr <= '0;
        end else if (i_cmd.clr_wr) begin
            r_clr_ptr <= clr_last ? '0 : r_clr_ptr + 1'b1;
        end
    end

    // update: saturating cell add, sector slot
    logic [pogb_pkg::CELL_W-1:0] rdata;
    logic [pogb_pkg::CELL_W:0]   sum;
    logic [pogb_pkg::CELL_W-1:0] sat;
    logic                        pt_commit;
    logic                        we;
    logic [pogb_pkg::ADDR_W-1:0] waddr;
    logic [pogb_pkg::CELL_W-1:0] wdata;

    assign sum = {1'b0, rdata} + {1'b0, r_hit_inc};
    assign sat = (sum > {1'b0, pogb_pkg::CELL_MAX}) ? pogb_pkg::CELL_MAX
                                                     : sum[pogb_pkg::CELL_W-1:0];
    assign pt_commit = i_cmd.commit && (r_op == pogb_pkg::OP_POINT) && r_in_range;

    always_comb begin
        if (i_cmd.clr_wr) begin
            we    = 1'b1;
            waddr = r_clr_ptr;
            wdata = '0;
        end else begin
            we    = pt_commit;
            waddr = r_addr;
            wdata = sat;
        end
    end

    pogb_ram #(
        .WIDTH (pogb_pkg::CELL_W),
        .DEPTH (pogb_pkg::CELL_COUNT)
    ) u_cells (
        .i_clk   (i_clk),
        .i_we    (we),
        .i_waddr (waddr),
        .i_wdata (wdata),
        .i_re    (re),
        .i_raddr (addr_c),
        .o_rdata (rdata)
    );

    logic [pogb_pkg::CNT_W-1:0] r_front, r_back, r_left, r_right;
    logic [pogb_pkg::CNT_W-1:0] slot_c;
    logic                       frame_commit;

    assign frame_commit = i_cmd.commit && (r_op == pogb_pkg::OP_FRAME);

    always_comb begin
        case (r_sec)
            pogb_pkg::SEC_FRONT: slot_c = r_front;
            pogb_pkg::SEC_BACK:  slot_c = r_back;
            pogb_pkg::SEC_LEFT:  slot_c = r_left;
            pogb_pkg::SEC_RIGHT: slot_c = r_right;
            default:             slot_c = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || frame_commit) begin
            r_front <= '0;
            r_back  <= '0;
            r_left  <= '0;
            r_right <= '0;
        end else if (pt_commit) begin
            case (r_sec)
                pogb_pkg::SEC_FRONT:
                    if (r_front != pogb_pkg::CNT_MAX) r_front <= r_front + 1'b1;
                pogb_pkg::SEC_BACK:
                    if (r_back != pogb_pkg::CNT_MAX) r_back <= r_back + 1'b1;
                pogb_pkg::SEC_LEFT:
                    if (r_left != pogb_pkg::CNT_MAX) r_left <= r_left + 1'b1;
                pogb_pkg::SEC_RIGHT:
                    if (r_right != pogb_pkg::CNT_MAX) r_right <= r_right + 1'b1;
                default: ;
            endcase
        end
    end

    // result register
    logic signed [pogb_pkg::COORD_W-1:0] neg_y;
    assign neg_y = (r_y == 16'sh8000) ? 16'sh7FFF : -r_y;

    logic                                r_o_in_range;
    logic [pogb_pkg::IDX_W-1:0]          r_o_cell_index;
    logic [pogb_pkg::CELL_W-1:0]         r_o_cell_value;
    logic [2:0]                          r_o_sector;
    logic signed [pogb_pkg::COORD_W-1:0] r_o_x, r_o_y;
    logic [pogb_pkg::CNT_W-1:0]          r_o_slot;
    logic [pogb_pkg::CNT_W-1:0]          r_o_front, r_o_back, r_o_left, r_o_right;

    always_ff @(posedge i_clk) begin
        if (i_cmd.commit) begin
            r_o_in_range   <= 1'b0;
            r_o_cell_index <= '0;
            r_o_cell_value <= '0;
            r_o_sector     <= pogb_pkg::SEC_NONE;
            r_o_x          <= '0;
            r_o_y          <= '0;
            r_o_slot       <= '0;
            r_o_front      <= '0;
            r_o_back       <= '0;
            r_o_left       <= '0;
            r_o_right      <= '0;
            case (r_op)
                pogb_pkg::OP_POINT: begin
                    if (r_in_range) begin
                        r_o_in_range   <= 1'b1;
                        r_o_cell_index <= pogb_pkg::IDX_W'(r_addr);
                        r_o_cell_value <= sat;
                        if (r_sec != pogb_pkg::SEC_NONE) begin
                            r_o_sector <= r_sec;
                            r_o_x      <= r_x;
                            r_o_y      <= neg_y;
                            r_o_slot   <= slot_c;
                        end
                    end
                end
                pogb_pkg::OP_READ: begin
                    r_o_cell_index <= r_rd_idx;
                    if (r_read_ok) begin
                        r_o_in_range   <= 1'b1;
                        r_o_cell_value <= rdata;
                    end
                end
                pogb_pkg::OP_FRAME: begin
                    r_o_front <= r_front;
                    r_o_back  <= r_back;
                    r_o_left  <= r_left;
                    r_o_right <= r_right;
                end
                default: ;
            endcase
        end
    end

    assign o_in_range    = r_o_in_range;
    assign o_cell_index  = r_o_cell_index;
    assign o_cell_value  = r_o_cell_value;
    assign o_sector      = r_o_sector;
    assign o_out_x       = r_o_x;
    assign o_out_y       = r_o_y;
    assign o_slot        = r_o_slot;
    assign o_front_count = r_o_front;
    assign o_back_count  = r_o_back;
    assign o_left_count  = r_o_left;
    assign o_right_count = r_o_right;

    assign o_status.is_frame = (r_op == pogb_pkg::OP_FRAME);
    assign o_status.clr_last = clr_last;

endmodule

[rtl/point_occupancy_grid_binner_core.sv]
// Top level of the point occupancy grid binner: controller plus datapath.
// Depends on pogb_pkg, pogb_ctrl, pogb_dp (and pogb_ram through it).
//
//   channel   direction  handshake              payload
//   in        input      i_in_valid/o_in_stall  i_op, i_point_x, i_point_y, i_read_index
//   out       output     o_out_valid/i_out_stall o_in_range .. o_right_count
//   cfg       input      i_cfg_we               i_cfg_idx, i_cfg_wdata
//
// A point, read or unused-op request steps through capture, address and cell read,
// then write-back; the read-modify-write on the single cell RAM sets this.
// A start-frame request does the same, then a sweep of all GRID_SIDE*GRID_SIDE
// (25600) cells that zeroes the cell RAM; no request is taken during the sweep.
// After reset the same sweep runs before the first request is taken.
// While a result is held by i_out_stall one more request may be captured; it waits
// in the write-back step until the result register frees.
module point_occupancy_grid_binner_core (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_in_valid,
    output logic                                o_in_stall,
    input  logic [1:0]                          i_op,
    input  logic signed [pogb_pkg::COORD_W-1:0] i_point_x,
    input  logic signed [pogb_pkg::COORD_W-1:0] i_point_y,
    input  logic [pogb_pkg::IDX_W-1:0]          i_read_index,
    output logic                                o_out_valid,
    input  logic                                i_out_stall,
    output logic                                o_in_range,
    output logic [pogb_pkg::IDX_W-1:0]          o_cell_index,
    output logic [pogb_pkg::CELL_W-1:0]         o_cell_value,
    output logic [2:0]                          o_sector,
    output logic signed [pogb_pkg::COORD_W-1:0] o_out_x,
    output logic signed [pogb_pkg::COORD_W-1:0] o_out_y,
    output logic [pogb_pkg::CNT_W-1:0]          o_slot,
    output logic [pogb_pkg::CNT_W-1:0]          o_front_count,
    output logic [pogb_pkg::CNT_W-1:0]          o_back_count,
    output logic [pogb_pkg::CNT_W-1:0]          o_left_count,
    output logic [pogb_pkg::CNT_W-1:0]          o_right_count,
    input  logic                                i_cfg_we,
    input  logic [pogb_pkg::CFG_IDX_W-1:0]      i_cfg_idx,
    input  logic [pogb_pkg::CFG_W-1:0]          i_cfg_wdata
);

    pogb_pkg::t_dp_cmd    cmd;
    pogb_pkg::t_dp_status status;

    pogb_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .i_status    (status),
        .o_cmd       (cmd)
    );

    pogb_dp u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (cmd),
        .o_status      (status),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_idx     (i_cfg_idx),
        .i_cfg_wdata   (i_cfg_wdata),
        .i_op          (i_op),
        .i_point_x     (i_point_x),
        .i_point_y     (i_point_y),
        .i_read_index  (i_read_index),
        .o_in_range    (o_in_range),
        .o_cell_index  (o_cell_index),
        .o_cell_value  (o_cell_value),
        .o_sector      (o_sector),
        .o_out_x       (o_out_x),
        .o_out_y       (o_out_y),
        .o_slot        (o_slot),
        .o_front_count (o_front_count),
        .o_back_count  (o_back_count),
        .o_left_count  (o_left_count),
        .o_right_count (o_right_count)
    );

endmodule
